[rtl/dtts_pkg.sv]
// dtts_pkg: shared types and constants of the delta timer task scheduler
// no dependencies
package dtts_pkg;

  localparam int TIMER_SLOTS_D = 16;
  localparam int TASK_SLOTS_D  = 16;
  localparam int TAG_BITS_D    = 8;
  localparam int DELAY_BITS_D  = 16;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_ADD  = 2'd1,
    OP_TAKE = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] delay_ticks;
    logic [7:0]  task_tag;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] ready_tag;
    logic [4:0] fired_count;
    logic [4:0] dropped_count;
    logic [4:0] pending_timers;
    logic [3:0] queued_tasks;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    op_t         op;
    logic [15:0] delay;
    logic [7:0]  tag;
  } cmd_t;

  typedef enum logic [2:0] {
    EX_IDLE,
    EX_WALK,
    EX_SHIFT,
    EX_TICK,
    EX_POP,
    EX_TAKE,
    EX_OUT
  } ex_state_t;

endpackage

[rtl/dtts_front.sv]
// dtts_front: accepts items, clamps zero delays, queues commands
// depends on dtts_pkg
module dtts_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dtts_pkg::in_item_t in_data,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output dtts_pkg::cmd_t    cmd_data
);
  import dtts_pkg::*;

  // two-entry command queue
  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t       c;

  always_comb begin
    c.op    = op_t'(in_data.operation);
    c.delay = (in_data.delay_ticks == 16'd0) ? 16'd1 : in_data.delay_ticks;
    c.tag   = in_data.task_tag;
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd_data  = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) q_r[wp_r] <= c;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp_r <= ~wp_r;
      if (cmd_valid && cmd_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'((in_valid && in_ready) ? 1 : 0)
                     - 2'((cmd_valid && cmd_ready) ? 1 : 0);
    end
  end
endmodule

[rtl/dtts_back.sv]
// dtts_back: delta list and task ring execution engine
// depends on dtts_pkg
module dtts_back #(
  parameter int TIMER_SLOTS = dtts_pkg::TIMER_SLOTS_D,
  parameter int TASK_SLOTS  = dtts_pkg::TASK_SLOTS_D
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  dtts_pkg::cmd_t      cmd_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dtts_pkg::out_item_t out_data
);
  import dtts_pkg::*;

  localparam int TI = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int RI = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int TC = $clog2(TIMER_SLOTS + 1);

  // list entries live in flops: the insert shift moves them all at once
  logic [15:0] dl_r  [TIMER_SLOTS];
  logic [7:0]  tg_r  [TIMER_SLOTS];
  logic [7:0]  ring_r [TASK_SLOTS];

  logic [TC-1:0] cnt_r;
  logic [RI-1:0] front_r, rear_r;
  ex_state_t     st_r, st_nxt;
  cmd_t          cmd_r;
  logic [TC-1:0] pos_r;
  logic [16:0]   before_r;
  logic [4:0]    fired_r, dropped_r;
  logic [1:0]    status_r;
  logic [7:0]    rtag_r;
  out_item_t     out_r;
  logic          ov_r;

  logic [TI-1:0] pidx;
  logic [16:0]   total;
  logic [RI-1:0] rnext, used;

  assign pidx  = pos_r[TI-1:0];
  assign total = before_r + {1'b0, dl_r[pidx]};
  assign rnext = (rear_r == RI'(TASK_SLOTS - 1)) ? '0 : rear_r + RI'(1);
  assign used  = (rear_r >= front_r) ? rear_r - front_r
                                     : RI'(TASK_SLOTS) - front_r + rear_r;

  assign cmd_ready = (st_r == EX_IDLE);
  assign out_valid = ov_r;
  assign out_data  = out_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      EX_IDLE:  if (cmd_valid) begin
        unique case (cmd_data.op)
          OP_TICK: st_nxt = (cnt_r == '0) ? EX_OUT : EX_TICK;
          OP_ADD:  st_nxt = (cnt_r == TC'(TIMER_SLOTS)) ? EX_OUT : EX_WALK;
          OP_TAKE: st_nxt = EX_TAKE;
          OP_NOP:  st_nxt = EX_OUT;
        endcase
      end
      EX_WALK:  if (pos_r == cnt_r || total >= {1'b0, cmd_r.delay}) st_nxt = EX_SHIFT;
      EX_SHIFT: st_nxt = EX_OUT;
      EX_TICK:  st_nxt = EX_POP;
      EX_POP:   if (cnt_r == '0 || dl_r[0] != 16'd0) st_nxt = EX_OUT;
      EX_TAKE:  st_nxt = EX_OUT;
      EX_OUT:   if (!ov_r || out_ready) st_nxt = EX_IDLE;
      default:  st_nxt = EX_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      EX_IDLE: if (cmd_valid) begin
        cmd_r <= cmd_data; before_r <= '0; fired_r <= '0; dropped_r <= '0;
        rtag_r <= '0;
        status_r <= (cmd_data.op == OP_ADD && cnt_r == TC'(TIMER_SLOTS)) ? ST_FULL
                  : (cmd_data.op == OP_TAKE && rear_r == front_r) ? ST_EMPTY : ST_DONE;
      end
      EX_WALK: if (!(pos_r == cnt_r || total >= {1'b0, cmd_r.delay}))
        before_r <= total;
      EX_SHIFT: begin
        for (int k = 1; k < TIMER_SLOTS; k++) begin
          if (TC'(k) > pos_r && TC'(k) <= cnt_r) begin
            // the entry pushed back keeps its deadline
            dl_r[k] <= (TC'(k) == pos_r + TC'(1))
                     ? dl_r[k-1] - 16'(cmd_r.delay - before_r[15:0])
                     : dl_r[k-1];
            tg_r[k] <= tg_r[k-1];
          end
        end
        dl_r[pidx] <= 16'(cmd_r.delay - before_r[15:0]);
        tg_r[pidx] <= cmd_r.tag;
      end
      EX_TICK: if (dl_r[0] != 16'd0) dl_r[0] <= dl_r[0] - 16'd1;
      EX_POP: if (cnt_r != '0 && dl_r[0] == 16'd0) begin
        if (rnext != front_r) begin
          ring_r[rnext] <= tg_r[0]; fired_r <= fired_r + 5'd1;
        end else dropped_r <= dropped_r + 5'd1;
        for (int k = 1; k < TIMER_SLOTS; k++) begin
          dl_r[k-1] <= dl_r[k]; tg_r[k-1] <= tg_r[k];
        end
      end
      EX_TAKE: if (status_r == ST_DONE)
        rtag_r <= ring_r[(front_r == RI'(TASK_SLOTS - 1)) ? '0 : front_r + RI'(1)];
      default: ;
    endcase
    if (st_r == EX_OUT && (!ov_r || out_ready)) begin
      out_r.status         <= status_r;
      out_r.ready_tag      <= rtag_r;
      out_r.fired_count    <= fired_r;
      out_r.dropped_count  <= dropped_r;
      out_r.pending_timers <= 5'(cnt_r);
      out_r.queued_tasks   <= 4'(used);
    end
    if (!rst_n) begin
      st_r <= EX_IDLE; cnt_r <= '0; front_r <= '0; rear_r <= '0; ov_r <= 1'b0;
      pos_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == EX_IDLE) pos_r <= '0;
      if (st_r == EX_WALK && !(pos_r == cnt_r || total >= {1'b0, cmd_r.delay}))
        pos_r <= pos_r + TC'(1);
      if (st_r == EX_SHIFT) cnt_r <= cnt_r + TC'(1);
      if (st_r == EX_POP && cnt_r != '0 && dl_r[0] == 16'd0) begin
        cnt_r <= cnt_r - TC'(1);
        if (rnext != front_r) rear_r <= rnext;
      end
      if (st_r == EX_TAKE && status_r == ST_DONE)
        front_r <= (front_r == RI'(TASK_SLOTS - 1)) ? '0 : front_r + RI'(1);
      if (st_r == EX_OUT && (!ov_r || out_ready)) ov_r <= 1'b1;
      else if (ov_r && out_ready) ov_r <= 1'b0;
    end
  end
endmodule

[rtl/delta_timer_task_scheduler_top.sv]
// delta_timer_task_scheduler_top: delta list timer queue with task ring
// depends on dtts_pkg, dtts_front, dtts_back
//
//   channel | signals                          | direction
//   in      | in_valid, in_ready, in_data      | item into the block
//   out     | out_valid, out_ready, out_data   | one result item per input
//
// the front queue registers each item before the back picks it up
// an add walks the list one entry a cycle in the back
// a tick pops one expired head a cycle
// take passes through EX_TAKE; empty tick, rejected add and other operations go straight to EX_OUT
// rst_n (synchronous) empties list and ring; stored entries are not cleared
// a two-entry queue lets the front take up to two more items while results stall
module delta_timer_task_scheduler_top #(
  parameter int TIMER_SLOTS = dtts_pkg::TIMER_SLOTS_D,
  parameter int TASK_SLOTS  = dtts_pkg::TASK_SLOTS_D
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dtts_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dtts_pkg::out_item_t out_data
);
  import dtts_pkg::*;

  logic cmd_valid, cmd_ready;
  cmd_t cmd_data;

  // front: clamp and queue
  dtts_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .cmd_valid, .cmd_ready, .cmd_data
  );

  // back: list walk, expiry, ring, output register
  dtts_back #(.TIMER_SLOTS(TIMER_SLOTS), .TASK_SLOTS(TASK_SLOTS)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd_data,
    .out_valid, .out_ready, .out_data
  );
endmodule
